/* rtl/core/rab_pkg.sv */
package rab_pkg;

  localparam int unsigned COORD_W     = 32;
  localparam int unsigned EXT_W       = 31;
  localparam int unsigned REG_IDX_W   = 3;
  localparam int unsigned FRAC_BITS_DEF = 16;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEFF_A = 3'd0,
    REG_COEFF_B = 3'd1,
    REG_COEFF_C = 3'd2,
    REG_COEFF_D = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5
  } reg_idx_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [EXT_W-1:0] ext_t;

  // per-stage load enables for the axis pipelines
  typedef struct packed {
    logic prod;
    logic order;
    logic sum;
    logic span;
  } rab_ctl_t;

endpackage

/* rtl/core/rab_rect_if.sv */
interface rab_rect_if
  import rab_pkg::*;
();
  logic   valid;
  logic   ready;
  coord_t rect_x;
  coord_t rect_y;
  coord_t rect_w;
  coord_t rect_h;

  modport source (output valid, output rect_x, output rect_y, output rect_w,
                  output rect_h, input ready);
  modport sink (input valid, input rect_x, input rect_y, input rect_w,
                input rect_h, output ready);
endinterface

/* rtl/core/rab_box_if.sv */
interface rab_box_if
  import rab_pkg::*;
();
  logic   valid;
  logic   ready;
  coord_t box_x;
  coord_t box_y;
  ext_t   box_w;
  ext_t   box_h;

  modport source (output valid, output box_x, output box_y, output box_w,
                  output box_h, input ready);
  modport sink (input valid, input box_x, input box_y, input box_w,
                input box_h, output ready);
endinterface

/* rtl/core/rect_affine_bounding_box.sv */
// Affine bounding box of a rectangle, signed fixed point with FRAC_BITS
// fraction bits.
// rect: valid/ready request channel carrying origin (rect_x, rect_y) and
//   extent (rect_w, rect_h); a request is taken when valid and ready are high.
// box: valid/ready result channel carrying the minimum mapped corner
//   (box_x, box_y) and the extent (box_w, box_h), one result per request.
// cfg_we/cfg_index/cfg_data write the matrix a, b, c, d and the translation
//   shift_x, shift_y; write them only while no request is in flight.
// Five register stages: corner adder (loaded at acceptance), multiplier
//   stage, min/max stage, adder with saturation, extent stage; box.valid
//   is the extent stage's valid. Throughput is one request per cycle while
//   box.ready is high; the 32x32 multipliers are one stage.
// When box.ready is low the stages hold their data and empty stages still
//   fill, so rect.ready drops only when all five stages are full.
// Reset clears all stage valids and loads the identity transform.
module rect_affine_bounding_box
  import rab_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  rab_rect_if.sink             rect,
  rab_box_if.source            box,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  localparam int unsigned STAGES = 5;

  coord_t coeff_a, coeff_b, coeff_c, coeff_d, shift_x, shift_y;

  logic [STAGES:1] vld;
  logic [STAGES:1] rdy;
  logic [STAGES:1] load;
  logic [STAGES:0] vin;

  coord_t   x0, x1, y0, y1;
  rab_ctl_t ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_a <= COORD_W'(64'd1 << FRAC_BITS);
      coeff_b <= '0;
      coeff_c <= '0;
      coeff_d <= COORD_W'(64'd1 << FRAC_BITS);
      shift_x <= '0;
      shift_y <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEFF_A: coeff_a <= cfg_data;
        REG_COEFF_B: coeff_b <= cfg_data;
        REG_COEFF_C: coeff_c <= cfg_data;
        REG_COEFF_D: coeff_d <= cfg_data;
        REG_SHIFT_X: shift_x <= cfg_data;
        REG_SHIFT_Y: shift_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage k is free when empty or when its contents move on
  assign vin = {vld, rect.valid};

  always_comb begin
    rdy[STAGES] = !vld[STAGES] || box.ready;
    for (int k = STAGES - 1; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
    for (int k = 1; k <= STAGES; k++) begin
      load[k] = rdy[k] && vin[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vin[k-1];
        end
      end
    end
  end

  assign ctl.prod  = load[2];
  assign ctl.order = load[3];
  assign ctl.sum   = load[4];
  assign ctl.span  = load[5];

  assign rect.ready = rdy[1];
  assign box.valid  = vld[STAGES];

  rab_corner u_corner (
    .clk    (clk),
    .en     (load[1]),
    .rect_x (rect.rect_x),
    .rect_y (rect.rect_y),
    .rect_w (rect.rect_w),
    .rect_h (rect.rect_h),
    .x0     (x0),
    .x1     (x1),
    .y0     (y0),
    .y1     (y1)
  );

  rab_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
    .clk     (clk),
    .ctl     (ctl),
    .k_x     (coeff_a),
    .k_y     (coeff_c),
    .t       (shift_x),
    .x0      (x0),
    .x1      (x1),
    .y0      (y0),
    .y1      (y1),
    .box_min (box.box_x),
    .box_ext (box.box_w)
  );

  rab_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
    .clk     (clk),
    .ctl     (ctl),
    .k_x     (coeff_b),
    .k_y     (coeff_d),
    .t       (shift_y),
    .x0      (x0),
    .x1      (x1),
    .y0      (y0),
    .y1      (y1),
    .box_min (box.box_y),
    .box_ext (box.box_h)
  );

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !rect.ready |-> (&vld) && !box.ready)
    else $error("input stalled with a free stage");

  a_hold_mid: assert property (@(posedge clk) disable iff (rst)
    vld[3] && !rdy[4] |=> vld[3])
    else $error("stalled stage lost its request");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    box.valid && !box.ready |=> box.valid)
    else $error("pending result dropped");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !box.valid)
    else $error("result valid after reset");

endmodule

/* rtl/core/rab_corner.sv */
module rab_corner
  import rab_pkg::*;
(
  input  logic   clk,
  input  logic   en,
  input  coord_t rect_x,
  input  coord_t rect_y,
  input  coord_t rect_w,
  input  coord_t rect_h,
  output coord_t x0,
  output coord_t x1,
  output coord_t y0,
  output coord_t y1
);

  logic signed [COORD_W:0] x_sum;
  logic signed [COORD_W:0] y_sum;
  coord_t                  x_far;
  coord_t                  y_far;

  function automatic coord_t sat_add(input logic signed [COORD_W:0] v);
    coord_t r;
    if (v[COORD_W] != v[COORD_W-1]) begin
      r = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  assign x_sum = (COORD_W+1)'(rect_x) + (COORD_W+1)'(rect_w);
  assign y_sum = (COORD_W+1)'(rect_y) + (COORD_W+1)'(rect_h);
  assign x_far = sat_add(x_sum);
  assign y_far = sat_add(y_sum);

  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= rect_x;
      y0 <= rect_y;
      x1 <= x_far;
      y1 <= y_far;
    end
  end

endmodule

/* rtl/core/rab_axis.sv */
module rab_axis
  import rab_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  rab_ctl_t ctl,
  input  coord_t   k_x,
  input  coord_t   k_y,
  input  coord_t   t,
  input  coord_t   x0,
  input  coord_t   x1,
  input  coord_t   y0,
  input  coord_t   y1,
  output coord_t   box_min,
  output ext_t     box_ext
);

  localparam int unsigned PROD_W = 2 * COORD_W;
  localparam int unsigned PW     = PROD_W - FRAC_BITS;
  localparam int unsigned SUM_W  = PW + 2;

  logic signed [PROD_W-1:0] mx0, mx1, my0, my1;
  logic signed [PROD_W-1:0] sx0, sx1, sy0, sy1;
  logic signed [PW-1:0]     px0, px1, py0, py1;
  logic signed [PW-1:0]     xmin, xmax, ymin, ymax;
  logic signed [SUM_W-1:0]  lo_sum, hi_sum;
  coord_t                   lo, hi;
  logic signed [COORD_W:0]  span;

  function automatic coord_t sat32(input logic signed [SUM_W-1:0] v);
    coord_t r;
    if (!((&v[SUM_W-1:COORD_W-1]) || (~|v[SUM_W-1:COORD_W-1]))) begin
      r = v[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // products floored by the arithmetic shift
  assign mx0 = k_x * x0;
  assign mx1 = k_x * x1;
  assign my0 = k_y * y0;
  assign my1 = k_y * y1;
  assign sx0 = mx0 >>> FRAC_BITS;
  assign sx1 = mx1 >>> FRAC_BITS;
  assign sy0 = my0 >>> FRAC_BITS;
  assign sy1 = my1 >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (ctl.prod) begin
      px0 <= sx0[PW-1:0];
      px1 <= sx1[PW-1:0];
      py0 <= sy0[PW-1:0];
      py1 <= sy1[PW-1:0];
    end
  end

  // terms separate per corner, so extremes of the sum come from extremes of each term
  always_ff @(posedge clk) begin
    if (ctl.order) begin
      xmin <= (px1 < px0) ? px1 : px0;
      xmax <= (px1 < px0) ? px0 : px1;
      ymin <= (py1 < py0) ? py1 : py0;
      ymax <= (py1 < py0) ? py0 : py1;
    end
  end

  assign lo_sum = SUM_W'(xmin) + SUM_W'(ymin) + SUM_W'(t);
  assign hi_sum = SUM_W'(xmax) + SUM_W'(ymax) + SUM_W'(t);

  always_ff @(posedge clk) begin
    if (ctl.sum) begin
      lo <= sat32(lo_sum);
      hi <= sat32(hi_sum);
    end
  end

  assign span = (COORD_W+1)'(hi) - (COORD_W+1)'(lo);

  always_ff @(posedge clk) begin
    if (ctl.span) begin
      box_min <= lo;
      box_ext <= (span[COORD_W:EXT_W] != '0) ? {EXT_W{1'b1}} : span[EXT_W-1:0];
    end
  end

endmodule

/* test/rab_box_checker.sv */
module rab_box_checker
  import rab_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  rab_rect_if                  rect,
  rab_box_if                   box,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  output int unsigned          mismatches,
  output int unsigned          pending,
  output int unsigned          checked
);

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct packed {
    coord_t x;
    coord_t y;
    ext_t   w;
    ext_t   h;
  } box_t;

  coord_t k_a, k_b, k_c, k_d, off_x, off_y;
  box_t   expected_boxes[$];

  function automatic longint clamp32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // floor-shifted products, summed exactly, then saturated
  function automatic longint map_axis(longint k1, longint p, longint k2, longint q,
                                      longint t);
    return clamp32(((k1 * p) >>> FRAC_BITS) + ((k2 * q) >>> FRAC_BITS) + t);
  endfunction

  function automatic box_t bound_rect(coord_t x, coord_t y, coord_t w, coord_t h);
    longint x0, y0, x1, y1, cx, cy, nx, ny;
    longint lo_x, hi_x, lo_y, hi_y;
    box_t   b;
    x0 = x;
    y0 = y;
    x1 = clamp32(x0 + longint'(w));
    y1 = clamp32(y0 + longint'(h));
    lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
    for (int i = 0; i < 4; i++) begin
      cx = i[0] ? x1 : x0;
      cy = i[1] ? y1 : y0;
      nx = map_axis(k_a, cx, k_c, cy, off_x);
      ny = map_axis(k_b, cx, k_d, cy, off_y);
      if (i == 0 || nx < lo_x) lo_x = nx;
      if (i == 0 || nx > hi_x) hi_x = nx;
      if (i == 0 || ny < lo_y) lo_y = ny;
      if (i == 0 || ny > hi_y) hi_y = ny;
    end
    b.x = coord_t'(lo_x);
    b.y = coord_t'(lo_y);
    b.w = ext_t'(clamp32(hi_x - lo_x));
    b.h = ext_t'(clamp32(hi_y - lo_y));
    return b;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at box %0d: %s", checked, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    box_t want;
    if (rst) begin
      k_a = coord_t'(1) << FRAC_BITS;
      k_b = '0;
      k_c = '0;
      k_d = coord_t'(1) << FRAC_BITS;
      off_x = '0;
      off_y = '0;
      expected_boxes.delete();
      mismatches = 0;
      checked = 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COEFF_A: k_a = coord_t'(cfg_data);
          REG_COEFF_B: k_b = coord_t'(cfg_data);
          REG_COEFF_C: k_c = coord_t'(cfg_data);
          REG_COEFF_D: k_d = coord_t'(cfg_data);
          REG_SHIFT_X: off_x = coord_t'(cfg_data);
          REG_SHIFT_Y: off_y = coord_t'(cfg_data);
          default: ;
        endcase
      end
      if (rect.valid && rect.ready) begin
        expected_boxes.push_back(bound_rect(rect.rect_x, rect.rect_y, rect.rect_w,
                                            rect.rect_h));
      end
      if (box.valid && box.ready) begin
        if (expected_boxes.size() == 0) begin
          report_mismatch($sformatf("box (%0d, %0d, %0d, %0d) with no request pending",
                                    box.box_x, box.box_y, box.box_w, box.box_h));
        end else begin
          want = expected_boxes.pop_front();
          if (box.box_x !== want.x)
            report_mismatch($sformatf("box_x got %0d, expected %0d", box.box_x, want.x));
          if (box.box_y !== want.y)
            report_mismatch($sformatf("box_y got %0d, expected %0d", box.box_y, want.y));
          if (box.box_w !== want.w)
            report_mismatch($sformatf("box_w got %0d, expected %0d", box.box_w, want.w));
          if (box.box_h !== want.h)
            report_mismatch($sformatf("box_h got %0d, expected %0d", box.box_h, want.h));
          checked++;
        end
      end
      pending <= expected_boxes.size();
    end
  end

endmodule

/* test/testbench.sv */
module testbench;
  import rab_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t ONE = coord_t'(1) << FRAC_BITS_DEF;
  localparam int unsigned SMALL_SPAN = 1 << 20;
  localparam int unsigned PHASES = 10;
  localparam int unsigned PHASE_RECTS = 160;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_data;

  rab_rect_if rect ();
  rab_box_if  box ();

  int unsigned mismatches, pending, checked;
  int unsigned send_idle_pct, stall_pct, cycles, rects_sent;

  rect_affine_bounding_box u_dut (
    .clk       (clk),
    .rst       (rst),
    .rect      (rect),
    .box       (box),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rab_box_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .rect       (rect),
    .box        (box),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    box.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d boxes outstanding", cycles, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic coord_t pick_coord();
    case ($urandom_range(9))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      3: return '1;
      4, 5, 6: return coord_t'($urandom_range(2 * SMALL_SPAN)) - coord_t'(SMALL_SPAN);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic coord_t pick_coeff();
    case ($urandom_range(9))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return ONE;
      3: return -ONE;
      4: return '0;
      5, 6, 7: return coord_t'($urandom_range(8 * ONE)) - 4 * ONE;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_rect(input coord_t x, input coord_t y, input coord_t w,
                           input coord_t h);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      rect.valid <= 1'b0;
      @(negedge clk);
    end
    rect.valid  <= 1'b1;
    rect.rect_x <= x;
    rect.rect_y <= y;
    rect.rect_w <= w;
    rect.rect_h <= h;
    @(posedge clk);
    while (!rect.ready) @(posedge clk);
    rects_sent++;
    @(negedge clk);
  endtask

  task automatic wait_all_boxes();
    rect.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_setting(input logic [REG_IDX_W-1:0] idx, input coord_t value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    coord_t a, b, c, d, sx, sy;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_COEFF_A;
    cfg_data = '0;
    rect.valid = 1'b0;
    rect.rect_x = '0;
    rect.rect_y = '0;
    rect.rect_w = '0;
    rect.rect_h = '0;
    box.ready = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    rects_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // unused indexes must leave the identity transform alone
    write_setting(REG_SPARE_LO, '1);
    write_setting(REG_SPARE_HI, coord_t'(32'h1234_5678));

    // zero-size and null rectangles
    send_rect('0, '0, '0, '0);
    send_rect('1, '1, '0, '0);
    send_rect(COORD_MAX, COORD_MIN, '0, '0);
    send_rect(COORD_MIN, COORD_MAX, '0, '0);
    // corner overflow on both ends
    send_rect(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_rect(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    send_rect(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    // wide box
    send_rect(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
    send_rect(COORD_MAX, '0, COORD_MIN, ONE);
    // negative extent
    send_rect(10 * ONE, 5 * ONE, -3 * ONE, -7 * ONE);
    send_rect(-ONE, ONE, ONE, -2 * ONE);
    send_rect(coord_t'(100), coord_t'(200), coord_t'(5), -coord_t'(5));
    send_rect('1, '1, '1, '1);
    send_rect(coord_t'(32'h5555_5555), coord_t'(32'haaaa_aaaa),
              coord_t'(32'h3333_3333), coord_t'(32'hcccc_cccc));
    send_rect(ONE, ONE, ONE, ONE);
    send_rect(COORD_MIN, '0, '1, COORD_MAX);

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        case (p)
          1: begin
            a = COORD_MAX; b = COORD_MAX; c = COORD_MAX;
            d = COORD_MAX; sx = COORD_MAX; sy = COORD_MAX;
          end
          2: begin
            a = COORD_MIN; b = COORD_MIN; c = COORD_MIN;
            d = COORD_MIN; sx = COORD_MIN; sy = COORD_MIN;
          end
          3: begin
            a = '0; b = ONE; c = -ONE; d = '0; sx = 100 * ONE; sy = -50 * ONE;
          end
          4: begin
            a = COORD_MAX; b = COORD_MIN; c = COORD_MIN;
            d = COORD_MAX; sx = COORD_MIN; sy = COORD_MAX;
          end
          5: begin
            a = -ONE; b = '1; c = ONE >>> 2; d = -(ONE >>> 1); sx = '1; sy = '0;
          end
          default: begin
            a = pick_coeff(); b = pick_coeff(); c = pick_coeff();
            d = pick_coeff(); sx = pick_coeff(); sy = pick_coeff();
          end
        endcase
        write_setting(REG_COEFF_A, a);
        write_setting(REG_COEFF_B, b);
        write_setting(REG_COEFF_C, c);
        write_setting(REG_COEFF_D, d);
        write_setting(REG_SHIFT_X, sx);
        write_setting(REG_SHIFT_Y, sy);
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 48; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 48; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      for (int n = 0; n < PHASE_RECTS; n++) begin
        if (n == PHASE_RECTS / 2) wait_all_boxes();
        send_rect(pick_coord(), pick_coord(), pick_coord(), pick_coord());
      end
      wait_all_boxes();
    end

    repeat (8) @(posedge clk);
    $display("%0d rectangles sent, %0d boxes checked, %0d transform settings",
             rects_sent, checked, PHASES);
    $display("identity, extreme, rotated and random matrices under mixed gaps and stalls");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
